// ----- hdl/recent_block_lru_prefetch_filter_defines.svh -----
// Assertion macros shared by the recent-block filter RTL.
`ifndef RECENT_BLOCK_LRU_PREFETCH_FILTER_DEFINES_SVH
`define RECENT_BLOCK_LRU_PREFETCH_FILTER_DEFINES_SVH

// Clocked check, muted while reset is high.
`define RBLPF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked check that also runs through reset.
`define RBLPF_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hdl/rblpf_pkg.sv -----
// Types and constants of the recent-block LRU prefetch filter.
`default_nettype none
package rblpf_pkg;

   localparam int LRU_ENTRIES_DEF = 64;
   localparam int CAP_W           = 7;
   localparam int VERDICT_W       = 3;

   typedef struct packed {
      logic [31:0] tablespace;
      logic [31:0] database;
      logic [31:0] relation;
      logic [1:0]  fork_num;
      logic [31:0] block;
   } key_type;

   typedef enum logic {
      FUNC_CLASSIFY = 1'b0,
      FUNC_CLEAR    = 1'b1
   } func_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_NO_KEY     = 3'd0,
      VERDICT_RECENT     = 3'd1,
      VERDICT_CACHED     = 3'd2,
      VERDICT_FULL_IMAGE = 3'd3,
      VERDICT_INIT_PAGE  = 3'd4,
      VERDICT_PREFETCH   = 3'd5,
      VERDICT_CLEARED    = 3'd6
   } verdict_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic update;   // classify beat with a key, cells may shift
      logic clear;    // drop every entry
      logic miss;     // no cell matched the key
   } cell_ctl_type;

endpackage
`default_nettype wire

// ----- hdl/rblpf_cell.sv -----
// One recency position of the LRU chain: a key, its valid bit and the hit carry.
`default_nettype none
module rblpf_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rblpf_pkg::cell_ctl_type     ctl,
   input  wire logic [rblpf_pkg::CAP_W-1:0] capacity,
   input  wire rblpf_pkg::key_type          req_key,
   input  wire rblpf_pkg::key_type          prev_key,
   input  wire logic                        prev_valid,
   input  wire logic                        carry_in,
   output rblpf_pkg::key_type               key_o,
   output logic                             valid_o,
   output logic                             hit_o,
   output logic                             carry_out
);
   import rblpf_pkg::*;

   key_type key_ff;
   key_type key_in;
   logic    valid_ff;
   logic    valid_in;
   logic    shift;
   logic    keep;

   assign hit_o     = valid_ff & (key_ff == req_key);
   // Carry: a hit at this position or further from the head.
   assign carry_out = hit_o | carry_in;
   // On a miss every position moves back; on a hit only those up to the hit.
   assign shift     = ctl.miss | carry_out;
   // Positions at or past the capacity drop out on a miss; position 0 always stays.
   assign keep      = (INDEX == 0) || (32'(INDEX) < 32'(capacity));

   assign key_in   = prev_key;
   assign valid_in = prev_valid & (keep | ~ctl.miss);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctl.update && shift) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.update && shift) begin
         key_ff <= key_in;
      end
   end

   assign key_o   = key_ff;
   assign valid_o = valid_ff;

endmodule
`default_nettype wire

// ----- hdl/recent_block_lru_prefetch_filter.sv -----
// Top level of the recent-block LRU prefetch filter: request latch, cell chain, verdict.
`default_nettype none
// Recent-block LRU prefetch filter. A beat is taken when start is high and
// busy is low; its verdict appears on rsp_verdict with rsp_valid high for
// exactly one cycle, registered from busy after the compute cycle, and the
// receiver cannot stall it. busy is high for one cycle after each accepted
// beat, so a new beat can be taken at the edge that ends the result cycle:
// the block takes no new beat while it is busy. busy spans the compute cycle, in
// which every cell compares its stored key against the latched key, the hit
// carry runs down the cell row and the row shifts in one step. The recent
// set is a row of LRU_ENTRIES cells ordered by recency, head = most recent.
// A hit moves the key to the head by shifting the cells in front of it back
// by one; a miss pushes the key in at the head and drops whatever falls past
// the capacity (csr_wdata, 0 acts as 1, above LRU_ENTRIES acts as
// LRU_ENTRIES). A new key is inserted even when the verdict is cached, full
// image or init. A clear beat empties the set. Write csr_we only while idle.
// No clearing pass after reset: the set is ready at once.
`include "recent_block_lru_prefetch_filter_defines.svh"
module recent_block_lru_prefetch_filter #(
   parameter int LRU_ENTRIES = rblpf_pkg::LRU_ENTRIES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_func,
   input  wire logic                        req_has_key,
   input  wire logic [31:0]                 req_tablespace_id,
   input  wire logic [31:0]                 req_database_id,
   input  wire logic [31:0]                 req_relation_id,
   input  wire logic [1:0]                  req_fork_number,
   input  wire logic [31:0]                 req_block_number,
   input  wire logic                        req_in_shared_buffers,
   input  wire logic                        req_has_full_image,
   input  wire logic                        req_heap_init_page,
   // result channel
   output logic                             rsp_valid,
   output rblpf_pkg::verdict_type           rsp_verdict,
   // configuration
   input  wire logic                        csr_we,
   input  wire logic [rblpf_pkg::CAP_W-1:0] csr_wdata
);
   import rblpf_pkg::*;

   // control
   logic busy_ff;
   logic rsp_valid_ff;
   logic [CAP_W-1:0] capacity_ff;

   // latched beat (payload, no reset)
   func_type    func_ff;
   logic        has_key_ff;
   key_type     key_ff;
   logic        shared_ff;
   logic        image_ff;
   logic        init_ff;
   verdict_type verdict_ff;
   verdict_type verdict_in;

   logic accept;
   cell_ctl_type ctl;

   // cell row wiring
   key_type                cell_key   [LRU_ENTRIES];
   logic [LRU_ENTRIES-1:0] valid_vec;
   logic [LRU_ENTRIES-1:0] hit_vec;
   logic [LRU_ENTRIES:0]   carry;

   assign accept = start & ~busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= CAP_W'(LRU_ENTRIES_DEF);
      end else begin
         busy_ff      <= accept;
         rsp_valid_ff <= busy_ff;   // verdict goes out right after the compute cycle
         if (csr_we) begin
            capacity_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff    <= func_type'(req_func);
         has_key_ff <= req_has_key;
         key_ff     <= '{tablespace: req_tablespace_id, database: req_database_id,
                         relation: req_relation_id, fork_num: req_fork_number,
                         block: req_block_number};
         shared_ff  <= req_in_shared_buffers;
         image_ff   <= req_has_full_image;
         init_ff    <= req_heap_init_page;
      end
      if (busy_ff) begin
         verdict_ff <= verdict_in;
      end
   end

   // Broadcast control for the compute cycle.
   assign ctl.update = busy_ff & (func_ff == FUNC_CLASSIFY) & has_key_ff;
   assign ctl.clear  = busy_ff & (func_ff == FUNC_CLEAR);
   assign ctl.miss   = ~carry[0];   // carry at the head = hit anywhere

   assign carry[LRU_ENTRIES] = 1'b0;

   genvar gi;
   generate
      for (gi = 0; gi < LRU_ENTRIES; gi++) begin : g_cell
         key_type prev_key;
         logic    prev_valid;
         if (gi == 0) begin : g_head
            // head takes the requested key, always as a valid entry
            assign prev_key   = key_ff;
            assign prev_valid = 1'b1;
         end else begin : g_body
            assign prev_key   = cell_key[gi-1];
            assign prev_valid = valid_vec[gi-1];
         end
         rblpf_cell #(
            .INDEX(gi)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .capacity   (capacity_ff),
            .req_key    (key_ff),
            .prev_key   (prev_key),
            .prev_valid (prev_valid),
            .carry_in   (carry[gi+1]),
            .key_o      (cell_key[gi]),
            .valid_o    (valid_vec[gi]),
            .hit_o      (hit_vec[gi]),
            .carry_out  (carry[gi])
         );
      end
   endgenerate

   // Verdict priority: clear, no key, recent, cached, full image, init, prefetch.
   always_comb begin
      case (func_ff)
         FUNC_CLEAR: begin
            verdict_in = VERDICT_CLEARED;
         end
         FUNC_CLASSIFY: begin
            if (!has_key_ff) begin
               verdict_in = VERDICT_NO_KEY;
            end else if (carry[0]) begin
               verdict_in = VERDICT_RECENT;
            end else if (shared_ff) begin
               verdict_in = VERDICT_CACHED;
            end else if (image_ff) begin
               verdict_in = VERDICT_FULL_IMAGE;
            end else if (init_ff) begin
               verdict_in = VERDICT_INIT_PAGE;
            end else begin
               verdict_in = VERDICT_PREFETCH;
            end
         end
         default: begin
            verdict_in = VERDICT_NO_KEY;
         end
      endcase
   end

   assign busy        = busy_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

   // Every accepted beat yields its verdict, through busy and then rsp_valid.
   `RBLPF_ASSERT(a_beat_to_rsp, accept |-> ##2 rsp_valid, "accepted beat lost its verdict")
   // Valid entries always fill the row from the head with no gap.
   `RBLPF_ASSERT(a_valid_packed, (valid_vec & (valid_vec + 1'b1)) == '0,
                 "gap in the valid cells of the LRU row")
   // Stored keys are distinct, so at most one cell can match.
   `RBLPF_ASSERT(a_single_hit, $onehot0(hit_vec), "key stored in two cells")
   // A cleared verdict leaves the row empty.
   `RBLPF_ASSERT(a_clear_empty, rsp_valid && (rsp_verdict == VERDICT_CLEARED) |-> valid_vec == '0,
                 "entries survived a clear")
   // Reset leaves the channel idle.
   `RBLPF_ASSERT_RST(a_reset_idle, reset |=> !busy && !rsp_valid, "activity right after reset")

endmodule
`default_nettype wire

// ----- tb/recent_block_lru_prefetch_filter_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the recent-block LRU prefetch filter: directed script, random phases.
module recent_block_lru_prefetch_filter_tb;
   import rblpf_pkg::*;

   localparam int SET_DEPTH   = LRU_ENTRIES_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 8;
   localparam int PHASE_REFS  = 170;     // 8 phases, ~1360 random beats
   localparam int MAX_REPORTS = 10;

   // Block key, laid out like the request ports.
   typedef struct packed {
      logic [31:0] ts;
      logic [31:0] db;
      logic [31:0] rel;
      logic [1:0]  fork_no;
      logic [31:0] blk;
   } block_key_t;

   // One request beat.
   typedef struct packed {
      func_type   func;
      logic       has_key;
      block_key_t key;
      logic       in_buf;
      logic       full_img;
      logic       init_pg;
   } block_ref_t;

   typedef enum logic {
      ROW_REF      = 1'b0,
      ROW_CAPACITY = 1'b1
   } row_kind_t;

   // Directed script row: a beat (with an optional hand-typed verdict) or a capacity write.
   typedef struct packed {
      row_kind_t        kind;
      block_ref_t       item;
      logic             typed;
      verdict_type      want;
      logic [CAP_W-1:0] cap;
   } script_row_t;

   localparam logic CHECK_TYPED     = 1'b1;
   localparam logic CHECK_PREDICTED = 1'b0;

   // {in_buf, full_img, init_pg}
   localparam logic [2:0] FL_NONE = 3'b000;
   localparam logic [2:0] FL_BUF  = 3'b100;
   localparam logic [2:0] FL_IMG  = 3'b010;
   localparam logic [2:0] FL_INIT = 3'b001;
   localparam logic [2:0] FL_ALL  = 3'b111;

   // Directed keys: A..F differ from A in one field each.
   localparam block_key_t KEY_A     = {32'd1663, 32'd16384, 32'd24576, 2'd0, 32'd0};
   localparam block_key_t KEY_A_FSM = {32'd1663, 32'd16384, 32'd24576, 2'd1, 32'd0};
   localparam block_key_t KEY_B     = {32'd1663, 32'd16384, 32'd24576, 2'd0, 32'd1};
   localparam block_key_t KEY_C     = {32'd1663, 32'd16384, 32'd24577, 2'd0, 32'd0};
   localparam block_key_t KEY_D     = {32'd1663, 32'd16385, 32'd24576, 2'd0, 32'd0};
   localparam block_key_t KEY_E     = {32'd1664, 32'd16384, 32'd24576, 2'd0, 32'd0};
   localparam block_key_t KEY_F     = {32'd1663, 32'd16384, 32'd24576, 2'd0, 32'h8000_0000};
   localparam block_key_t KEY_ONES  = '1;
   localparam block_key_t KEY_ZERO  = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             start = 1'b0;
   logic             busy;
   logic             req_func = 1'b0;
   logic             req_has_key = 1'b0;
   logic [31:0]      req_tablespace_id = '0;
   logic [31:0]      req_database_id = '0;
   logic [31:0]      req_relation_id = '0;
   logic [1:0]       req_fork_number = '0;
   logic [31:0]      req_block_number = '0;
   logic             req_in_shared_buffers = 1'b0;
   logic             req_has_full_image = 1'b0;
   logic             req_heap_init_page = 1'b0;
   logic             rsp_valid;
   verdict_type      rsp_verdict;
   logic             csr_we = 1'b0;
   logic [CAP_W-1:0] csr_wdata = '0;

   recent_block_lru_prefetch_filter u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_func              (req_func),
      .req_has_key           (req_has_key),
      .req_tablespace_id     (req_tablespace_id),
      .req_database_id       (req_database_id),
      .req_relation_id       (req_relation_id),
      .req_fork_number       (req_fork_number),
      .req_block_number      (req_block_number),
      .req_in_shared_buffers (req_in_shared_buffers),
      .req_has_full_image    (req_has_full_image),
      .req_heap_init_page    (req_heap_init_page),
      .rsp_valid             (rsp_valid),
      .rsp_verdict           (rsp_verdict),
      .csr_we                (csr_we),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow of the recent set. Index 0 is the most recent key; the tail is
   // the next victim. set_capacity mirrors the register as written (raw
   // 7 bits); clamping happens at use.
   // ---------------------------------------------------------------------
   block_key_t       recent_keys[$];
   logic [CAP_W-1:0] set_capacity = 7'd64;

   verdict_type pending_verdicts[$];   // verdicts owed by the block, oldest first
   int          mismatch_count = 0;
   script_row_t script_rows[$];

   function automatic int usable_entries(logic [CAP_W-1:0] cap);
      if (cap == 0)
         return 1;
      if (cap > SET_DEPTH)
         return SET_DEPTH;
      return int'(cap);
   endfunction

   // Updates the shadow set for one beat and returns its verdict.
   function automatic verdict_type classify_reference(block_ref_t r);
      int         hit;
      int         room;
      hit = -1;
      if (r.func == FUNC_CLEAR) begin
         recent_keys.delete();
         return VERDICT_CLEARED;
      end
      if (!r.has_key)
         return VERDICT_NO_KEY;
      for (int i = 0; i < recent_keys.size(); i++)
         if (hit < 0 && recent_keys[i] == r.key)
            hit = i;
      if (hit >= 0) begin
         // hit: move to the head, nothing evicted even if over capacity
         recent_keys.delete(hit);
         recent_keys.push_front(r.key);
         return VERDICT_RECENT;
      end
      // miss: trim the tail until there is room, also after a capacity cut
      room = usable_entries(set_capacity);
      while (recent_keys.size() >= room)
         void'(recent_keys.pop_back());
      recent_keys.push_front(r.key);
      // key goes in regardless of how the beat is then classified
      if (r.in_buf)
         return VERDICT_CACHED;
      if (r.full_img)
         return VERDICT_FULL_IMAGE;
      if (r.init_pg)
         return VERDICT_INIT_PAGE;
      return VERDICT_PREFETCH;
   endfunction

   task automatic count_fault(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s", $realtime, msg);
   endtask

   // ---------------------------------------------------------------------
   // Result side: one verdict per strobe, never back-pressured.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_verdict
      verdict_type want;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            count_fault($sformatf("verdict %0d with no beat outstanding", rsp_verdict));
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_verdict !== want)
               count_fault($sformatf("verdict: expected %0d, got %0d", want, rsp_verdict));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side. Fields and start change only at rising edges. After the
   // accepting edge start is left high when the next beat follows at once;
   // the caller then drives it in the same step.
   // ---------------------------------------------------------------------
   task automatic send_ref(block_ref_t r, int idle_pct, logic typed, verdict_type want);
      verdict_type got;
      req_func              <= r.func;
      req_has_key           <= r.has_key;
      req_tablespace_id     <= r.key.ts;
      req_database_id       <= r.key.db;
      req_relation_id       <= r.key.rel;
      req_fork_number       <= r.key.fork_no;
      req_block_number      <= r.key.blk;
      req_in_shared_buffers <= r.in_buf;
      req_has_full_image    <= r.full_img;
      req_heap_init_page    <= r.init_pg;
      start                 <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      // beat taken at this edge
      got = classify_reference(r);
      pending_verdicts.push_back(typed ? want : got);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         // random gaps land on both the busy cycle and the free cycle
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Capacity writes only with the block drained.
   task automatic write_capacity(logic [CAP_W-1:0] value);
      start <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      set_capacity = value;
      csr_we <= 1'b0;
   endtask

   task automatic add_ref(func_type f, logic hk, block_key_t k, logic [2:0] flags,
                          logic typed, verdict_type want);
      script_row_t row;
      row = '0;
      row.kind          = ROW_REF;
      row.item.func     = f;
      row.item.has_key  = hk;
      row.item.key      = k;
      row.item.in_buf   = flags[2];
      row.item.full_img = flags[1];
      row.item.init_pg  = flags[0];
      row.typed         = typed;
      row.want          = want;
      script_rows.push_back(row);
   endtask

   task automatic add_cap(logic [CAP_W-1:0] value);
      script_row_t row;
      row = '0;
      row.kind = ROW_CAPACITY;
      row.cap  = value;
      script_rows.push_back(row);
   endtask

   // Watchdog.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("recent_block_lru_prefetch_filter: mismatch");
      $finish;
   end

   initial begin
      int               cap_plan[8];
      int               idle_plan[8];
      int               roll;
      int               room;
      int               bit_idx;
      logic [2:0]       flags;
      logic [CAP_W-1:0] cap;
      logic [129:0]     key_bits;
      block_key_t       key_pool[$];
      block_key_t       k;
      block_ref_t       r;

      // Extremes first: 0 acts as 1, 127 acts as the full set, 65 just past it.
      cap_plan  = '{64, 1, 127, 0, 2, 65, 16, 63};
      // sender idle percentage per phase; receiver cannot stall
      idle_plan = '{0, 74, 16, 0, 74, 16, 0, 74};

      // Directed script, capacity 64 out of reset.
      add_ref(FUNC_CLASSIFY, 1'b0, KEY_A,     FL_ALL,  CHECK_TYPED, VERDICT_NO_KEY);
      add_ref(FUNC_CLEAR,    1'b1, KEY_A,     FL_NONE, CHECK_TYPED, VERDICT_CLEARED);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_A,     FL_NONE, CHECK_TYPED, VERDICT_PREFETCH);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_A,     FL_NONE, CHECK_TYPED, VERDICT_RECENT);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_B,     FL_BUF,  CHECK_TYPED, VERDICT_CACHED);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_C,     FL_IMG,  CHECK_TYPED, VERDICT_FULL_IMAGE);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_D,     FL_INIT, CHECK_TYPED, VERDICT_INIT_PAGE);
      // flag priority: buffers, then image, then init
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_E,     FL_ALL,  CHECK_TYPED, VERDICT_CACHED);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_F,     FL_IMG | FL_INIT, CHECK_TYPED,
              VERDICT_FULL_IMAGE);
      // cached key inserted above, so this is a hit despite the flags
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_B,     FL_ALL,  CHECK_TYPED, VERDICT_RECENT);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_ONES,  FL_NONE, CHECK_TYPED, VERDICT_PREFETCH);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_ZERO,  FL_NONE, CHECK_TYPED, VERDICT_PREFETCH);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_A_FSM, FL_NONE, CHECK_PREDICTED, VERDICT_NO_KEY);
      // key fields present but no key flag: set untouched
      add_ref(FUNC_CLASSIFY, 1'b0, KEY_A_FSM, FL_ALL,  CHECK_TYPED, VERDICT_NO_KEY);
      add_ref(FUNC_CLEAR,    1'b0, KEY_ZERO,  FL_ALL,  CHECK_TYPED, VERDICT_CLEARED);
      // single entry: every new key evicts the previous one
      add_cap(7'd1);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_A,     FL_NONE, CHECK_TYPED, VERDICT_PREFETCH);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_B,     FL_NONE, CHECK_TYPED, VERDICT_PREFETCH);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_A,     FL_NONE, CHECK_TYPED, VERDICT_PREFETCH);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_A,     FL_NONE, CHECK_TYPED, VERDICT_RECENT);
      // zero behaves as one
      add_cap(7'd0);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_B,     FL_NONE, CHECK_TYPED, VERDICT_PREFETCH);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_B,     FL_NONE, CHECK_TYPED, VERDICT_RECENT);
      // above the set size, then cut back below the fill
      add_cap(7'd127);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_C,     FL_NONE, CHECK_PREDICTED, VERDICT_NO_KEY);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_D,     FL_NONE, CHECK_PREDICTED, VERDICT_NO_KEY);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_E,     FL_NONE, CHECK_PREDICTED, VERDICT_NO_KEY);
      add_cap(7'd2);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_E,     FL_NONE, CHECK_PREDICTED, VERDICT_NO_KEY);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_F,     FL_NONE, CHECK_PREDICTED, VERDICT_NO_KEY);
      add_ref(FUNC_CLASSIFY, 1'b1, KEY_C,     FL_NONE, CHECK_PREDICTED, VERDICT_NO_KEY);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script_rows[i]) begin
         if (script_rows[i].kind == ROW_CAPACITY)
            write_capacity(script_rows[i].cap);
         else
            send_ref(script_rows[i].item, 0, script_rows[i].typed, script_rows[i].want);
      end

      // Random phases. Keys come mostly from a pool sized around the
      // capacity so hits, evictions and reinsertions all happen; some are
      // one-bit neighbors of pool keys to probe every compare bit.
      for (int phase = 0; phase < 8; phase++) begin
         cap = (phase == 7) ? CAP_W'($urandom_range(127)) : CAP_W'(cap_plan[phase]);
         write_capacity(cap);
         room = usable_entries(cap);
         key_pool.delete();
         repeat (room + $urandom_range(0, room) + 1) begin
            k.ts      = $urandom;
            k.db      = $urandom;
            k.rel     = $urandom;
            k.fork_no = 2'($urandom_range(3));
            k.blk     = $urandom;
            key_pool.push_back(k);
         end
         for (int n = 0; n < PHASE_REFS; n++) begin
            roll = $urandom_range(99);
            k = key_pool[$urandom_range(key_pool.size() - 1)];
            if (roll >= 70 && roll < 85) begin
               key_bits = k;
               bit_idx = $urandom_range(129);
               key_bits[bit_idx] = ~key_bits[bit_idx];
               k = key_bits;
            end else if (roll >= 85) begin
               k.ts      = $urandom;
               k.db      = $urandom;
               k.rel     = $urandom;
               k.fork_no = 2'($urandom_range(3));
               k.blk     = $urandom;
            end
            roll = $urandom_range(99);
            flags = 3'($urandom_range(7));
            r.func     = (roll < 2) ? FUNC_CLEAR : FUNC_CLASSIFY;
            r.has_key  = (roll >= 2 && roll < 8) ? 1'b0 : 1'b1;
            r.key      = k;
            r.in_buf   = flags[2];
            r.full_img = flags[1];
            r.init_pg  = flags[0];
            send_ref(r, idle_plan[phase], CHECK_PREDICTED, VERDICT_NO_KEY);
         end
      end

      start <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_verdicts.size() == 0)
         $display("recent_block_lru_prefetch_filter: match");
      else
         $display("recent_block_lru_prefetch_filter: mismatch");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rblpf_pkg.sv
hdl/rblpf_cell.sv
hdl/recent_block_lru_prefetch_filter.sv
tb/recent_block_lru_prefetch_filter_tb.sv
